>>> src/assert_macros.svh
// Assertion helpers for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> src/ggnh_pkg.sv
`timescale 1ns / 1ps
package ggnh_pkg;

   localparam int NEIGHBORS_DEFAULT = 16;
   localparam int ADDR_W            = 16;
   localparam int COORD_W           = 16;
   localparam int SQ_W              = 2 * COORD_W + 1;
   localparam int DIST_W            = SQ_W + 1;
   localparam int STATUS_W          = 3;
   localparam int CSR_INDEX_W       = 4;

   localparam logic FUNC_BEACON = 1'b0;
   localparam logic FUNC_ROUTE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_UPDATED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_INSERTED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FORWARD  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_ATDEST   = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_NOROUTE  = 3'd5;

   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_X = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_Y = 4'd1;

   // Position of the current word, seen by every cell at once.
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } ggnh_dest_type;

   // Word that walks along the row of cells, one cell per cycle.
   typedef struct packed {
      logic                      active;
      logic                      func;
      logic [ADDR_W-1:0]         addr;
      logic [DIST_W-1:0]         best;
      logic                      found;
      logic                      inserted;
      logic [ADDR_W-1:0]         hop_addr;
      logic signed [COORD_W-1:0] hop_x;
      logic signed [COORD_W-1:0] hop_y;
   } ggnh_token_type;

endpackage

>>> src/ggnh_cell.sv
`timescale 1ns / 1ps
module ggnh_cell #(
   parameter int NEIGHBORS = ggnh_pkg::NEIGHBORS_DEFAULT,
   parameter int INDEX     = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ggnh_pkg::ggnh_dest_type              dest,
   input  logic [$clog2(NEIGHBORS+1)-1:0]       count,
   input  ggnh_pkg::ggnh_token_type             token_in,
   output ggnh_pkg::ggnh_token_type             token_out
);
   import ggnh_pkg::*;

   localparam int CNT_W = $clog2(NEIGHBORS + 1);
   localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

   logic [ADDR_W-1:0]         addr_ff;
   logic signed [COORD_W-1:0] x_ff;
   logic signed [COORD_W-1:0] y_ff;
   logic [SQ_W-1:0]           sqx_ff;
   logic [SQ_W-1:0]           sqy_ff;
   ggnh_token_type            token_ff;
   ggnh_token_type            token_in_next;

   logic signed [COORD_W:0]     dx;
   logic signed [COORD_W:0]     dy;
   logic signed [2*COORD_W+1:0] prod_x;
   logic signed [2*COORD_W+1:0] prod_y;
   logic [DIST_W-1:0]           span_sum;
   logic                        occupied;
   logic                        wr_pos;
   logic                        wr_addr;

   // The squares follow the stored entry and the broadcast position in every cycle.
   always_comb begin
      dx     = $signed({x_ff[COORD_W-1], x_ff}) - $signed({dest.x[COORD_W-1], dest.x});
      dy     = $signed({y_ff[COORD_W-1], y_ff}) - $signed({dest.y[COORD_W-1], dest.y});
      prod_x = dx * dx;
      prod_y = dy * dy;
   end

   always_ff @(posedge clock) begin
      sqx_ff <= prod_x[SQ_W-1:0];
      sqy_ff <= prod_y[SQ_W-1:0];
   end

   assign span_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign occupied = (IDX < count);

   always_comb begin
      token_in_next = token_in;
      wr_pos        = 1'b0;
      wr_addr       = 1'b0;
      if (token_in.active) begin
         if (token_in.func == FUNC_BEACON) begin
            priority if (token_in.found) begin
               wr_pos = 1'b0;
            end else if (occupied && (addr_ff == token_in.addr)) begin
               wr_pos              = 1'b1;
               token_in_next.found = 1'b1;
            end else if (IDX == count) begin
               wr_pos                 = 1'b1;
               wr_addr                = 1'b1;
               token_in_next.found    = 1'b1;
               token_in_next.inserted = 1'b1;
            end else begin
               wr_pos = 1'b0;
            end
         end else if (occupied && (span_sum <= token_in.best)) begin
            token_in_next.best     = span_sum;
            token_in_next.found    = 1'b1;
            token_in_next.hop_addr = addr_ff;
            token_in_next.hop_x    = x_ff;
            token_in_next.hop_y    = y_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_pos) begin
         x_ff <= dest.x;
         y_ff <= dest.y;
      end
      if (wr_addr) begin
         addr_ff <= token_in.addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= '0;
      end else begin
         token_ff <= token_in_next;
      end
   end

   assign token_out = token_ff;

endmodule

>>> src/greedy_geographic_next_hop_top.sv
// Greedy geographic next-hop selector with a neighbour table of NEIGHBORS entries.
// Command channel: a word is taken at a rising edge where start is high and busy is
// low. req_func low is a beacon (req_node_addr, req_pos_x, req_pos_y refresh or append
// a neighbour); req_func high is a route query towards req_pos_x, req_pos_y.
// Result channel: rsp_valid is high for exactly one cycle with rsp_status and the
// chosen hop. The receiver cannot stall, so the result is simply presented once.
// Configuration channel: csr_valid/csr_ready with csr_index 0 for own x and 1 for own
// y; other indexes are ignored. csr_ready is high whenever no word is in flight.
// Sequence: the accepted word passes S_SQUARE (squaring), S_SUM (summing the own
// distance) and S_LAUNCH, then crosses the row of cells at one cell per cycle; the
// result is registered, and the result strobe rises as busy falls, so one word is
// handled at a time and a new one is taken only once the previous result is out.
// Reset clears the entry count, the own position and all control state; busy is high
// and csr_ready low while it is held. Table entries hold whatever they held and are
// only read below the entry count.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module greedy_geographic_next_hop_top #(
   parameter int NEIGHBORS = ggnh_pkg::NEIGHBORS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_func,
   input  logic [ggnh_pkg::ADDR_W-1:0]            req_node_addr,
   input  logic signed [ggnh_pkg::COORD_W-1:0]    req_pos_x,
   input  logic signed [ggnh_pkg::COORD_W-1:0]    req_pos_y,
   output logic                                   rsp_valid,
   output logic [ggnh_pkg::STATUS_W-1:0]          rsp_status,
   output logic [ggnh_pkg::ADDR_W-1:0]            rsp_hop_addr,
   output logic signed [ggnh_pkg::COORD_W-1:0]    rsp_hop_x,
   output logic signed [ggnh_pkg::COORD_W-1:0]    rsp_hop_y,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ggnh_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [ggnh_pkg::COORD_W-1:0]           csr_data
);
   import ggnh_pkg::*;

   localparam int CNT_W = $clog2(NEIGHBORS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SQUARE,
      S_SUM,
      S_LAUNCH,
      S_WALK
   } state_type;

   state_type                 state_ff;
   logic signed [COORD_W-1:0] own_x_ff;
   logic signed [COORD_W-1:0] own_y_ff;
   ggnh_dest_type             dest_ff;
   logic                      func_ff;
   logic [ADDR_W-1:0]         addr_ff;
   logic [SQ_W-1:0]           own_sqx_ff;
   logic [SQ_W-1:0]           own_sqy_ff;
   logic [DIST_W-1:0]         own_sum_ff;
   logic                      at_dest_ff;
   logic [CNT_W-1:0]          count_ff;
   logic                      rsp_valid_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [ADDR_W-1:0]         rsp_hop_addr_ff;
   logic signed [COORD_W-1:0] rsp_hop_x_ff;
   logic signed [COORD_W-1:0] rsp_hop_y_ff;

   logic                        accept;
   logic signed [COORD_W:0]     own_dx;
   logic signed [COORD_W:0]     own_dy;
   logic signed [2*COORD_W+1:0] own_prod_x;
   logic signed [2*COORD_W+1:0] own_prod_y;
   ggnh_token_type              launch_token;
   ggnh_token_type              chain [0:NEIGHBORS];
   ggnh_token_type              tail;
   logic [STATUS_W-1:0]         status_in;
   logic                        forward_in;
   logic                        rsp_hop_ok;

   assign busy      = reset || (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = !reset && (state_ff == S_IDLE);

   // Own position registers; writes arrive only while no word is in flight.
   always_ff @(posedge clock) begin
      if (reset) begin
         own_x_ff <= '0;
         own_y_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OWN_X: own_x_ff <= $signed(csr_data);
            CSR_OWN_Y: own_y_ff <= $signed(csr_data);
            default: begin
            end
         endcase
      end
   end

   // The accepted word is held for the whole walk; its position goes to every cell.
   always_ff @(posedge clock) begin
      if (accept) begin
         dest_ff.x <= req_pos_x;
         dest_ff.y <= req_pos_y;
         func_ff   <= req_func;
         addr_ff   <= req_node_addr;
      end
   end

   // Own distance to the destination: the squares are registered first, then their sum.
   always_comb begin
      own_dx     = $signed({own_x_ff[COORD_W-1], own_x_ff})
                 - $signed({dest_ff.x[COORD_W-1], dest_ff.x});
      own_dy     = $signed({own_y_ff[COORD_W-1], own_y_ff})
                 - $signed({dest_ff.y[COORD_W-1], dest_ff.y});
      own_prod_x = own_dx * own_dx;
      own_prod_y = own_dy * own_dy;
   end

   always_ff @(posedge clock) begin
      own_sqx_ff <= own_prod_x[SQ_W-1:0];
      own_sqy_ff <= own_prod_y[SQ_W-1:0];
      own_sum_ff <= {1'b0, own_sqx_ff} + {1'b0, own_sqy_ff};
      at_dest_ff <= (own_x_ff == dest_ff.x) && (own_y_ff == dest_ff.y);
   end

   // The launch word enters the first cell for a single cycle.
   always_comb begin
      launch_token        = '0;
      launch_token.active = (state_ff == S_LAUNCH);
      launch_token.func   = func_ff;
      launch_token.addr   = addr_ff;
      launch_token.best   = own_sum_ff;
   end

   assign chain[0] = launch_token;

   // One cell per table entry; each holds its entry and passes the word on.
   for (genvar i = 0; i < NEIGHBORS; i++) begin : g_cell
      ggnh_cell #(
         .NEIGHBORS (NEIGHBORS),
         .INDEX     (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .dest      (dest_ff),
         .count     (count_ff),
         .token_in  (chain[i]),
         .token_out (chain[i+1])
      );
   end

   assign tail = chain[NEIGHBORS];

   // Decode of the word leaving the last cell.
   always_comb begin
      forward_in = 1'b0;
      if (tail.func == FUNC_BEACON) begin
         priority if (tail.inserted) begin
            status_in = STATUS_INSERTED;
         end else if (tail.found) begin
            status_in = STATUS_UPDATED;
         end else begin
            status_in = STATUS_FULL;
         end
      end else begin
         priority if (at_dest_ff) begin
            status_in = STATUS_ATDEST;
         end else if (tail.found) begin
            status_in  = STATUS_FORWARD;
            forward_in = 1'b1;
         end else begin
            status_in = STATUS_NOROUTE;
         end
      end
   end

   // A new entry was appended by the first free cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if ((state_ff == S_WALK) && tail.active && (tail.func == FUNC_BEACON)
                   && tail.inserted) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   // Sequencer and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == S_WALK) && tail.active;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_SQUARE;
               end
            end
            S_SQUARE: state_ff <= S_SUM;
            S_SUM:    state_ff <= S_LAUNCH;
            S_LAUNCH: state_ff <= S_WALK;
            S_WALK: begin
               if (tail.active) begin
                  state_ff        <= S_IDLE;
                  rsp_status_ff   <= status_in;
                  rsp_hop_addr_ff <= forward_in ? tail.hop_addr : '0;
                  rsp_hop_x_ff    <= forward_in ? tail.hop_x : '0;
                  rsp_hop_y_ff    <= forward_in ? tail.hop_y : '0;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_hop_addr = rsp_hop_addr_ff;
   assign rsp_hop_x    = rsp_hop_x_ff;
   assign rsp_hop_y    = rsp_hop_y_ff;

   assign rsp_hop_ok = !(rsp_valid && (rsp_status != STATUS_FORWARD))
                       || ((rsp_hop_addr == '0) && (rsp_hop_x == '0) && (rsp_hop_y == '0));

   // The strobe is never held over, since a new word must cross the whole row first.
   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "result strobe held over")
   // An accepted word keeps the block busy in the following cycle.
   `ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "accepted word not busy")
   // The table never claims more entries than it has cells.
   `ASSERT_CLK(a_count_max, clock, reset, count_ff <= CNT_W'(NEIGHBORS), "entry count overflow")
   // Only a forwarded result carries a hop.
   `ASSERT_CLK(a_hop_zero, clock, reset, rsp_hop_ok, "hop on non-forward result")

endmodule
